// ===== design/scd_pkg.sv =====
// shared types, sizes and result codes for the sleep countdown table
package scd_pkg;

    // table geometry
    localparam int SLOTS   = 16;
    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int ID_W    = 8;
    localparam int TICKS_W = 32;
    localparam int REM_W   = 31;
    localparam int ENTRY_W = ID_W + REM_W;

    // item kinds
    localparam logic FUNC_SLEEP = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_ACCEPTED = 2'd0;
    localparam logic [1:0] KIND_IGNORED  = 2'd1;
    localparam logic [1:0] KIND_FULL     = 2'd2;
    localparam logic [1:0] KIND_WOKEN    = 2'd3;

    // input beat
    typedef struct packed {
        logic                       func;
        logic [ID_W-1:0]            thread_id;
        logic signed [TICKS_W-1:0]  sleep_ticks;
    } in_t;

    // result beat
    typedef struct packed {
        logic [1:0]      kind;
        logic [ID_W-1:0] woken_id;
        logic            last;
    } out_t;

    // controller to datapath
    typedef struct packed {
        logic accept_item;
        logic start_scan;
        logic sleep_finish;
        logic scan_step;
        logic scan_finish;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic count_zero;
        logic last_entry;
        logic step_ok;
        logic pend_valid;
    } ctrl_st_t;

endpackage

// ===== design/scd_ram.sv =====
// generic simple dual-port ram with registered read
module scd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/scd_ctrl.sv =====
// controller state machine for the sleep countdown table
module scd_ctrl import scd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_func,
    output logic      s_ready,
    input  ctrl_st_t  st,
    output ctrl_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SLEEP = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept_item = 1'b1;
                    if (s_func == FUNC_TICK) begin
                        cmd.start_scan = 1'b1;
                        state_next     = st.count_zero ? ST_FIN : ST_SCAN;
                    end else begin
                        state_next = ST_SLEEP;
                    end
                end
            end
            ST_SLEEP: begin
                if (st.out_free) begin
                    cmd.sleep_finish = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (st.step_ok) begin
                    cmd.scan_step = 1'b1;
                    if (st.last_entry) begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                if (!st.pend_valid || st.out_free) begin
                    cmd.scan_finish = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // a scan step only goes ahead when a held wake result can leave
    a_step_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_step |-> st.step_ok)
        else $error("scan step taken while blocked");

    // an empty table skips the scan
    a_empty_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.start_scan && st.count_zero) |=> (state_reg == ST_FIN))
        else $error("empty table did not skip the scan");

endmodule

// ===== design/scd_dp.sv =====
// datapath: item register, table ram, scan counters and result register
module scd_dp import scd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_t       s_data,
    input  logic      m_ready,
    output out_t      m_data,
    output logic      m_valid,
    input  ctrl_cmd_t cmd,
    output ctrl_st_t  st
);

    in_t              item_reg;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] wr_idx_reg, wr_idx_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]  pend_id_reg, pend_id_next;
    out_t             out_reg, out_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_load;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [ID_W-1:0]  entry_id;
    logic [REM_W-1:0] entry_rem;
    logic [REM_W-1:0] entry_dec;
    logic             entry_woken;
    logic [CNT_W-1:0] rd_idx_inc;
    logic             out_free;
    logic             nonpositive;
    logic             table_full;
    logic [1:0]       sleep_kind;

    // table storage: thread id over remaining ticks
    scd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // entry decode and sleep classification
    assign entry_id    = ram_rdata[ENTRY_W-1 -: ID_W];
    assign entry_rem   = ram_rdata[REM_W-1:0];
    assign entry_woken = (entry_rem == REM_W'(1));
    assign entry_dec   = (entry_rem == '0) ? entry_rem : entry_rem - REM_W'(1);
    assign rd_idx_inc  = rd_idx_reg + CNT_W'(1);
    assign out_free    = !out_valid_reg || m_ready;
    assign nonpositive = (item_reg.sleep_ticks == '0) || item_reg.sleep_ticks[TICKS_W-1];
    assign table_full  = (count_reg == CNT_W'(SLOTS));

    always_comb begin
        priority if (nonpositive) begin
            sleep_kind = KIND_IGNORED;
        end else if (table_full) begin
            sleep_kind = KIND_FULL;
        end else begin
            sleep_kind = KIND_ACCEPTED;
        end
    end

    // status to the controller
    assign st.out_free   = out_free;
    assign st.count_zero = (count_reg == '0);
    assign st.last_entry = (rd_idx_inc == count_reg);
    assign st.step_ok    = !(entry_woken && pend_valid_reg && !out_free);
    assign st.pend_valid = pend_valid_reg;

    // read port: entry 0 on scan start, then one ahead of the step
    assign ram_re    = cmd.start_scan || cmd.scan_step;
    assign ram_raddr = cmd.start_scan ? '0 : rd_idx_inc[IDX_W-1:0];

    // next state of counters, pending wake and result register
    always_comb begin
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        wr_idx_next     = wr_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        out_next        = out_reg;
        out_load        = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = wr_idx_reg[IDX_W-1:0];
        ram_wdata       = {entry_id, entry_dec};

        if (cmd.sleep_finish) begin
            out_load = 1'b1;
            out_next = '{kind: sleep_kind, woken_id: item_reg.thread_id, last: 1'b1};
            if (sleep_kind == KIND_ACCEPTED) begin
                ram_we     = 1'b1;
                ram_waddr  = count_reg[IDX_W-1:0];
                ram_wdata  = {item_reg.thread_id, item_reg.sleep_ticks[REM_W-1:0]};
                count_next = count_reg + CNT_W'(1);
            end
        end

        if (cmd.start_scan) begin
            rd_idx_next     = '0;
            wr_idx_next     = '0;
            pend_valid_next = 1'b0;
        end

        if (cmd.scan_step) begin
            rd_idx_next = rd_idx_inc;
            if (entry_woken) begin
                // the earlier wake leaves, not the last of the run
                if (pend_valid_reg) begin
                    out_load = 1'b1;
                    out_next = '{kind: KIND_WOKEN, woken_id: pend_id_reg, last: 1'b0};
                end
                pend_valid_next = 1'b1;
                pend_id_next    = entry_id;
            end else begin
                // keep the entry, packed down to the write index
                ram_we      = 1'b1;
                wr_idx_next = wr_idx_reg + CNT_W'(1);
            end
        end

        if (cmd.scan_finish) begin
            if (pend_valid_reg) begin
                out_load = 1'b1;
                out_next = '{kind: KIND_WOKEN, woken_id: pend_id_reg, last: 1'b1};
            end
            pend_valid_next = 1'b0;
            count_next      = wr_idx_reg;
        end

        out_valid_next = out_load || (out_valid_reg && !m_ready);
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            wr_idx_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            count_reg      <= count_next;
            rd_idx_reg     <= rd_idx_next;
            wr_idx_reg     <= wr_idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept_item) begin
            item_reg <= s_data;
        end
        pend_id_reg <= pend_id_next;
        out_reg     <= out_next;
    end

    assign m_data  = out_reg;
    assign m_valid = out_valid_reg;

    // fill count never passes the table size
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(SLOTS))
        else $error("fill count beyond table size");

    // compaction never writes ahead of the read side
    a_wr_behind_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_idx_reg <= rd_idx_reg)
        else $error("write index ahead of read index");

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result register overwritten");

endmodule

// ===== design/sleep_countdown_table.sv =====
// top level of the sleep countdown table: controller plus datapath
//
//   channel | ports                      | direction | beat
//   --------+----------------------------+-----------+-----------------------------
//   input   | s_valid, s_ready, s_data   | in        | func, thread_id, sleep_ticks
//   result  | m_valid, m_ready, m_data   | out       | kind, woken_id, last
//
// a sleep request is captured in the item register, and its result is loaded once the
// result port is free. a tick starts with a read of entry 0, steps through the entries
// (one read of the table ram per cycle while no held wake blocks it) and then closes.
// reset empties the table through the fill count; the ram needs no clearing.
// a stalled result port holds a sleep request, a tick at each wake after the first,
// and the close of a tick while its final wake is still held.
module sleep_countdown_table import scd_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    ctrl_cmd_t cmd;
    ctrl_st_t  st;

    // sequencing
    scd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_data.func),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // storage and result path
    scd_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_data  (m_data),
        .m_valid (m_valid),
        .cmd     (cmd),
        .st      (st)
    );

endmodule
